// ===== design/palette_nearest_color_search_top_defines.svh =====
// Assertion macros shared by the palette search checker.
`ifndef PALETTE_NEAREST_COLOR_SEARCH_TOP_DEFINES_SVH
`define PALETTE_NEAREST_COLOR_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PNC_ASSERT_NOW(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PNC_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== design/pnc_pkg.sv =====
// Types and constants shared by the palette nearest-color search block.
package pnc_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_FIND  = 2'd2;

  localparam logic REG_COLORS_USED      = 1'b0;
  localparam logic REG_COLORS_IMPORTANT = 1'b1;

  // Command kinds after classification.
  localparam logic [1:0] K_ZERO  = 2'd0;  // answer all zeros, no state change
  localparam logic [1:0] K_WRITE = 2'd1;
  localparam logic [1:0] K_READ  = 2'd2;
  localparam logic [1:0] K_QUERY = 2'd3;

  localparam int CNT_W  = 9;
  localparam int DIST_W = 18;
  localparam logic [DIST_W-1:0] START_DISTANCE = 18'd200000;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       entry_index;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic [CNT_W-1:0] count;
  } cmd_t;

endpackage

// ===== design/pnc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pnc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/pnc_front.sv =====
// Front end: accepts items and classifies them into queued commands.
module pnc_front import pnc_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       opcode,
  input  logic [7:0]       entry_index,
  input  logic [7:0]       red,
  input  logic [7:0]       green,
  input  logic [7:0]       blue,
  input  logic [7:0]       alpha,
  input  logic [CNT_W-1:0] colors_used,
  input  logic [CNT_W-1:0] colors_important,
  input  logic             q_full,
  output logic             q_push,
  output cmd_t             q_cmd
);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(PALETTE_DEPTH);

  logic             in_range;
  logic [CNT_W-1:0] base_cnt;
  logic [CNT_W-1:0] lim_cnt;
  logic [CNT_W-1:0] eff_cnt;

  always_comb begin
    in_range = ({1'b0, entry_index} < colors_used) &&
               (CNT_W'(entry_index) < DEPTH_CNT);
    base_cnt = (colors_important == '0) ? colors_used : colors_important;
    lim_cnt  = (colors_used > DEPTH_CNT) ? DEPTH_CNT : colors_used;
    eff_cnt  = (base_cnt > lim_cnt) ? lim_cnt : base_cnt;
  end

  always_comb begin
    q_cmd.entry_index = entry_index;
    q_cmd.red         = red;
    q_cmd.green       = green;
    q_cmd.blue        = blue;
    q_cmd.alpha       = alpha;
    q_cmd.count       = eff_cnt;
    case (opcode)
      OP_WRITE: q_cmd.kind = in_range ? K_WRITE : K_ZERO;
      OP_READ:  q_cmd.kind = in_range ? K_READ : K_ZERO;
      // a palette not in use answers index zero
      OP_FIND:  q_cmd.kind = (colors_used == '0) ? K_ZERO : K_QUERY;
      default:  q_cmd.kind = K_ZERO;
    endcase
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ===== design/pnc_queue.sv =====
// Two-entry command queue between front and back end.
module pnc_queue import pnc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t dout
);

  cmd_t                   slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   fill;

  assign full  = (fill == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign valid = (fill != '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== design/pnc_back.sv =====
// Back end: palette store, one-entry query cache, distance search, result register.
module pnc_back import pnc_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       accepted,
  output logic [7:0] nearest_index,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha
);

  localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]             state;
  cmd_t                   cmd;
  logic [PALETTE_DEPTH-1:0] entry_valid;

  logic        cache_valid;
  logic [23:0] cached_color;
  logic [7:0]  cached_index;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [31:0]      ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [31:0]      ram_rdata;
  logic             rd_ok;
  logic [31:0]      entry;

  logic [CNT_W-1:0] iss_cnt;
  logic             issue;
  logic             p1_v;
  logic [IDX_W-1:0] p1_idx;
  logic             p2_v;
  logic [IDX_W-1:0] p2_idx;
  logic [15:0]      sq_r;
  logic [15:0]      sq_g;
  logic [15:0]      sq_b;
  logic [DIST_W-1:0] cur_dist;
  logic [DIST_W-1:0] best_dist;
  logic [IDX_W-1:0] best_idx;
  logic             hit_zero;
  logic             better;
  logic             last;
  logic [IDX_W-1:0] win_idx;

  logic        res_accepted;
  logic [7:0]  res_nearest;
  logic [31:0] res_entry;
  logic        out_free;
  logic [23:0] key;
  logic        cache_hit;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  pnc_ram #(
    .WIDTH(32),
    .DEPTH(PALETTE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    q_pop     = (state == ST_IDLE) && q_valid;
    issue     = (state == ST_SEARCH) && (iss_cnt < cmd.count);
    ram_we    = q_pop && (q_cmd.kind == K_WRITE);
    ram_waddr = q_cmd.entry_index[IDX_W-1:0];
    ram_wdata = {q_cmd.alpha, q_cmd.red, q_cmd.green, q_cmd.blue};
    ram_raddr = (state == ST_SEARCH) ? iss_cnt[IDX_W-1:0]
                                     : q_cmd.entry_index[IDX_W-1:0];
    // entries never written read as zero
    entry     = rd_ok ? ram_rdata : 32'd0;
    key       = {q_cmd.red, q_cmd.green, q_cmd.blue};
    cache_hit = (q_cmd.kind == K_QUERY) && cache_valid && (cached_color == key);
    cur_dist  = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
    hit_zero  = (cur_dist == '0);
    better    = hit_zero || (cur_dist < best_dist);
    last      = (CNT_W'(p2_idx) == (cmd.count - 1'b1));
    win_idx   = better ? p2_idx : best_idx;
    out_free  = !out_valid || out_ready;
  end

  // search pipeline: address, registered read, squares, sum and compare
  always_ff @(posedge clk) begin
    rd_ok  <= entry_valid[ram_raddr];
    p1_idx <= iss_cnt[IDX_W-1:0];
    p2_idx <= p1_idx;
    sq_r   <= 16'(abs_diff(entry[23:16], cmd.red)) * 16'(abs_diff(entry[23:16], cmd.red));
    sq_g   <= 16'(abs_diff(entry[15:8], cmd.green)) * 16'(abs_diff(entry[15:8], cmd.green));
    sq_b   <= 16'(abs_diff(entry[7:0], cmd.blue)) * 16'(abs_diff(entry[7:0], cmd.blue));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
    end else begin
      p1_v <= issue;
      p2_v <= p1_v && (state == ST_SEARCH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      entry_valid  <= '0;
      cache_valid  <= 1'b0;
      cached_color <= '0;
      cached_index <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cmd          <= q_cmd;
            res_accepted <= (q_cmd.kind == K_WRITE);
            res_nearest  <= cache_hit ? cached_index : 8'd0;
            res_entry    <= '0;
            case (q_cmd.kind)
              K_WRITE: begin
                entry_valid[ram_waddr] <= 1'b1;
                cache_valid            <= 1'b0;
                state                  <= ST_FINISH;
              end
              K_READ: begin
                state <= ST_READ;
              end
              K_QUERY: begin
                if (cache_hit) begin
                  state <= ST_FINISH;
                end else begin
                  cached_color <= key;
                  cache_valid  <= 1'b1;
                  iss_cnt      <= '0;
                  best_idx     <= '0;
                  best_dist    <= START_DISTANCE;
                  state        <= ST_SEARCH;
                end
              end
              default: begin
                state <= ST_FINISH;
              end
            endcase
          end
        end
        ST_READ: begin
          res_accepted <= 1'b1;
          res_entry    <= entry;
          state        <= ST_FINISH;
        end
        ST_SEARCH: begin
          if (issue) begin
            iss_cnt <= iss_cnt + 1'b1;
          end
          if (p2_v) begin
            if (better) begin
              best_dist <= cur_dist;
              best_idx  <= p2_idx;
            end
            // stop at the first exact match or after the last entry
            if (hit_zero || last) begin
              res_nearest  <= 8'(win_idx);
              cached_index <= 8'(win_idx);
              state        <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            accepted      <= res_accepted;
            nearest_index <= res_nearest;
            out_red       <= res_entry[23:16];
            out_green     <= res_entry[15:8];
            out_blue      <= res_entry[7:0];
            out_alpha     <= res_entry[31:24];
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/palette_nearest_color_search_top.sv =====
// Palette nearest-color search: keeps up to PALETTE_DEPTH RGBA entries and answers
// write, read and nearest-color queries, one result beat per input beat, in order.
// Input beats go into a two-entry command queue, so the input side keeps taking
// beats while a result waits on the output, until the queue is full. Commands run
// one at a time. A query that hits the one-entry cache is answered from it; a
// query that misses walks the effective entries of the palette one entry per cycle
// through the single read port of the palette RAM and one squared-distance unit.
// The search ends early on an exact match. Entries not yet written read as zero;
// no clearing pass is needed after reset.
module palette_nearest_color_search_top import pnc_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] opcode,
  input  logic [7:0] entry_index,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [7:0] alpha,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       accepted,
  output logic [7:0] nearest_index,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha
);

  logic [CNT_W-1:0] colors_used;
  logic [CNT_W-1:0] colors_important;
  logic             q_full;
  logic             q_push;
  cmd_t             q_din;
  logic             q_valid;
  logic             q_pop;
  cmd_t             q_dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      colors_used      <= '0;
      colors_important <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COLORS_USED:      colors_used      <= cfg_data;
        REG_COLORS_IMPORTANT: colors_important <= cfg_data;
        default:              colors_used      <= colors_used;
      endcase
    end
  end

  pnc_front #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .entry_index     (entry_index),
    .red             (red),
    .green           (green),
    .blue            (blue),
    .alpha           (alpha),
    .colors_used     (colors_used),
    .colors_important(colors_important),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (q_din)
  );

  pnc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_din),
    .full (q_full),
    .pop  (q_pop),
    .valid(q_valid),
    .dout (q_dout)
  );

  pnc_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_dout),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .accepted     (accepted),
    .nearest_index(nearest_index),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_alpha    (out_alpha)
  );

endmodule

// ===== design/pnc_checker.sv =====
// Port-level checker for the palette search block, bound to the top level.
`include "palette_nearest_color_search_top_defines.svh"

module pnc_checker #(
  parameter int PALETTE_DEPTH = 256
) (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       accepted,
  input logic [7:0] nearest_index,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha
);

  logic [2:0] pending;
  logic [2:0] pending_next;

  // beats taken in minus beats delivered
  always_comb begin
    pending_next = pending;
    if (in_valid && in_ready) begin
      pending_next = pending_next + 3'd1;
    end
    if (out_valid && out_ready) begin
      pending_next = pending_next - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending_next;
    end
  end

  `PNC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(nearest_index) && $stable(out_red) && $stable(accepted), "result beat changed while stalled")

  `PNC_ASSERT_NOW(a_no_extra_result, clk, rst, out_valid, pending != 3'd0, "result beat without a pending item")

  `PNC_ASSERT_NOW(a_reject_zero, clk, rst, out_valid && !accepted, (out_red == 8'd0) && (out_green == 8'd0) && (out_blue == 8'd0) && (out_alpha == 8'd0), "rejected or query beat carries entry data")

  `PNC_ASSERT_NOW(a_query_shape, clk, rst, out_valid && (nearest_index != 8'd0), !accepted && (nearest_index < PALETTE_DEPTH), "query answer malformed")

endmodule

bind palette_nearest_color_search_top pnc_checker #(
  .PALETTE_DEPTH(PALETTE_DEPTH)
) u_pnc_checker (.*);

// ===== tb/sv/palette_nearest_color_search_top_tb.sv =====
// Testbench for the palette nearest-color search block: predicts every result beat and checks it.
`timescale 1ns / 100ps

module palette_nearest_color_search_top_tb;
  import pnc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_PCT = 29;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } beat_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] nearest_index;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } answer_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_index = 1'b0;
  logic [8:0] cfg_data = 9'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] opcode = OP_WRITE;
  logic [7:0] entry_index = 8'd0;
  logic [7:0] red = 8'd0;
  logic [7:0] green = 8'd0;
  logic [7:0] blue = 8'd0;
  logic [7:0] alpha = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       accepted;
  logic [7:0] nearest_index;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  palette_nearest_color_search_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .entry_index   (entry_index),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .alpha         (alpha),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .accepted      (accepted),
    .nearest_index (nearest_index),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha)
  );

  // Predicted block state.
  logic [31:0] palette_mem [256];
  logic [23:0] memo_color = 24'd0;
  logic [7:0]  memo_index = 8'd0;
  logic        memo_valid = 1'b0;
  logic [8:0]  used_count = 9'd0;
  logic [8:0]  important_count = 9'd0;

  // Stimulus planning state, runs ahead of the driver.
  logic [23:0] plan_color [256];
  logic [23:0] last_query_color = 24'd0;
  int unsigned plan_used = 0;

  beat_t       beats_to_send [$];
  answer_t     expected_answers [$];
  int unsigned mismatch_count = 0;
  int unsigned idle_pct = IDLE_PCT;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 50)
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic int unsigned channel_gap(input logic [7:0] a, input logic [7:0] b);
    int d;
    d = int'(a) - int'(b);
    return d * d;
  endfunction

  function automatic logic [7:0] nearest_entry(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
    int unsigned span;
    int unsigned best_gap;
    int unsigned gap_sum;
    int unsigned i;
    logic [7:0]  best;
    logic        exact;
    if (used_count == 0)
      return 8'd0;
    if (memo_valid && memo_color == {r, g, b})
      return memo_index;
    memo_color = {r, g, b};
    memo_valid = 1'b1;
    span = (important_count == 0) ? used_count : important_count;
    if (span > used_count) span = used_count;
    if (span > 256) span = 256;
    best = 8'd0;
    best_gap = START_DISTANCE;
    exact = 1'b0;
    // First entry with the least gap wins; stop on an exact match.
    for (i = 0; i < span && !exact; i++) begin
      gap_sum = channel_gap(palette_mem[i[7:0]][23:16], r)
              + channel_gap(palette_mem[i[7:0]][15:8], g)
              + channel_gap(palette_mem[i[7:0]][7:0], b);
      if (gap_sum == 0) begin
        best = i[7:0];
        exact = 1'b1;
      end else if (gap_sum < best_gap) begin
        best_gap = gap_sum;
        best = i[7:0];
      end
    end
    memo_index = best;
    return best;
  endfunction

  task automatic predict_palette_beat(input beat_t beat);
    answer_t res;
    logic    in_range;
    res = '0;
    in_range = {1'b0, beat.entry_index} < used_count;
    case (beat.opcode)
      OP_WRITE: begin
        if (in_range) begin
          palette_mem[beat.entry_index] = {beat.alpha, beat.red, beat.green, beat.blue};
          memo_valid = 1'b0;
          res.accepted = 1'b1;
        end
      end
      OP_READ: begin
        if (in_range) begin
          res.accepted = 1'b1;
          {res.out_alpha, res.out_red, res.out_green, res.out_blue} =
            palette_mem[beat.entry_index];
        end
      end
      OP_FIND: res.nearest_index = nearest_entry(beat.red, beat.green, beat.blue);
      default: ;
    endcase
    expected_answers.push_back(res);
  endtask

  // Driver: hold the beat until accepted, then offer the next one or idle.
  always @(posedge clk) begin
    beat_t next_beat;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        predict_palette_beat({opcode, entry_index, red, green, blue, alpha});
      if (!in_valid || in_ready) begin
        if (beats_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_beat = beats_to_send.pop_front();
          in_valid <= 1'b1;
          opcode <= next_beat.opcode;
          entry_index <= next_beat.entry_index;
          red <= next_beat.red;
          green <= next_beat.green;
          blue <= next_beat.blue;
          alpha <= next_beat.alpha;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_ready <= 1'b0;
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Monitor: compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_answers.size() == 0) begin
        report_mismatch("result beat with nothing expected, nearest_index", nearest_index, 0);
      end else begin
        want = expected_answers.pop_front();
        if (accepted !== want.accepted)
          report_mismatch("accepted", accepted, want.accepted);
        if (nearest_index !== want.nearest_index)
          report_mismatch("nearest_index", nearest_index, want.nearest_index);
        if (out_red !== want.out_red)
          report_mismatch("out_red", out_red, want.out_red);
        if (out_green !== want.out_green)
          report_mismatch("out_green", out_green, want.out_green);
        if (out_blue !== want.out_blue)
          report_mismatch("out_blue", out_blue, want.out_blue);
        if (out_alpha !== want.out_alpha)
          report_mismatch("out_alpha", out_alpha, want.out_alpha);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_beat(input logic [1:0] op, input logic [7:0] idx, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b, input logic [7:0] a);
    if (op == OP_WRITE && idx < plan_used)
      plan_color[idx] = {r, g, b};
    if (op == OP_FIND)
      last_query_color = {r, g, b};
    beats_to_send.push_back({op, idx, r, g, b, a});
  endtask

  function automatic logic [7:0] rand_level();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      3: return 8'd64;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] nudge(input logic [7:0] v);
    int t;
    t = int'(v) + int'($urandom_range(8)) - 4;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return t[7:0];
  endfunction

  function automatic logic [7:0] pick_index();
    if (plan_used != 0 && $urandom_range(9) != 0)
      return 8'($urandom_range(plan_used - 1));
    return 8'($urandom_range(255));
  endfunction

  task automatic queue_random_phase(input int unsigned count);
    int unsigned k;
    int unsigned pick;
    int unsigned mode;
    logic [23:0] c;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      mode = $urandom_range(99);
      // Seed the palette first so queries have something to find.
      if (plan_used != 0 && k < 16) begin
        queue_beat(OP_WRITE, 8'($urandom_range(plan_used - 1)), rand_level(), rand_level(),
                   rand_level(), 8'($urandom_range(255)));
      end else if (pick < 30) begin
        queue_beat(OP_WRITE, pick_index(), rand_level(), rand_level(), rand_level(),
                   8'($urandom_range(255)));
      end else if (pick < 45) begin
        queue_beat(OP_READ, pick_index(), 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
      end else if (pick < 92) begin
        if (plan_used != 0 && mode < 30) begin
          c = plan_color[8'($urandom_range(plan_used - 1))];
        end else if (mode < 50) begin
          c = last_query_color;
        end else if (plan_used != 0 && mode < 70) begin
          c = plan_color[8'($urandom_range(plan_used - 1))];
          c = {nudge(c[23:16]), nudge(c[15:8]), nudge(c[7:0])};
        end else begin
          c = {rand_level(), rand_level(), rand_level()};
        end
        queue_beat(OP_FIND, 8'($urandom_range(255)), c[23:16], c[15:8], c[7:0],
                   8'($urandom_range(255)));
      end else begin
        queue_beat(2'($urandom_range(3)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
      end
    end
  endtask

  task automatic wait_until_drained();
    while (beats_to_send.size() != 0 || in_valid || expected_answers.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic reg_index, input logic [8:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= reg_index;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (reg_index == REG_COLORS_USED) begin
      used_count = value;
      plan_used = value;
    end else begin
      important_count = value;
    end
  endtask

  task automatic set_palette_config(input logic [8:0] used, input logic [8:0] important);
    wait_until_drained();
    write_register(REG_COLORS_USED, used);
    write_register(REG_COLORS_IMPORTANT, important);
    @(negedge clk);
  endtask

  initial begin
    int unsigned phase_used [12];
    int unsigned phase_important [12];
    int unsigned phase_items [12];
    int unsigned p;
    for (p = 0; p < 256; p++) begin
      palette_mem[p[7:0]] = 32'd0;
      plan_color[p[7:0]] = 24'd0;
    end
    phase_used      = '{256, 17, 1, 256, 40, 255, 0, 3, 64, 256, 120, 2};
    phase_important = '{0, 5, 0, 256, 200, 1, 0, 0, 0, 16, 120, 256};
    phase_items     = '{150, 80, 40, 80, 80, 60, 20, 60, 100, 80, 80, 50};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Not indexed: writes and reads rejected, query answers entry 0.
    queue_beat(OP_WRITE, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_beat(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    queue_beat(OP_FIND, 8'd0, 8'd10, 8'd20, 8'd30, 8'd0);
    queue_beat(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

    set_palette_config(9'd8, 9'd0);
    queue_beat(OP_WRITE, 8'd0, 8'd10, 8'd10, 8'd10, 8'h00);
    queue_beat(OP_WRITE, 8'd1, 8'd0, 8'd0, 8'd0, 8'hFF);
    queue_beat(OP_WRITE, 8'd2, 8'd200, 8'd100, 8'd50, 8'h5A);
    queue_beat(OP_WRITE, 8'd3, 8'd10, 8'd10, 8'd10, 8'hA5);
    queue_beat(OP_WRITE, 8'd4, 8'd128, 8'd128, 8'd128, 8'h33);
    queue_beat(OP_WRITE, 8'd5, 8'd255, 8'd255, 8'd255, 8'hCC);
    queue_beat(OP_WRITE, 8'd8, 8'd255, 8'd255, 8'd255, 8'hFF);
    queue_beat(OP_WRITE, 8'd255, 8'd1, 8'd2, 8'd3, 8'd4);
    queue_beat(OP_READ, 8'd5, 8'd0, 8'd0, 8'd0, 8'd0);
    queue_beat(OP_READ, 8'd7, 8'd0, 8'd0, 8'd0, 8'd0);
    queue_beat(OP_READ, 8'd8, 8'd0, 8'd0, 8'd0, 8'd0);
    queue_beat(OP_FIND, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0);
    queue_beat(OP_FIND, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0);
    // Ties between equal entries go to the lower index.
    queue_beat(OP_FIND, 8'd0, 8'd11, 8'd11, 8'd11, 8'd0);
    queue_beat(OP_FIND, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    queue_beat(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

    // Register writes keep the cached answer, even when it is now out of the searched set.
    set_palette_config(9'd8, 9'd3);
    queue_beat(OP_FIND, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0);
    queue_beat(OP_FIND, 8'd0, 8'd250, 8'd250, 8'd250, 8'd0);
    queue_beat(OP_WRITE, 8'd0, 8'd10, 8'd10, 8'd10, 8'h00);
    queue_beat(OP_FIND, 8'd0, 8'd250, 8'd250, 8'd250, 8'd0);

    for (p = 0; p < 12; p++) begin
      set_palette_config(9'(phase_used[p]), 9'(phase_important[p]));
      idle_pct = (p == 3) ? 0 : IDLE_PCT;
      queue_random_phase(phase_items[p]);
      // Stall the output long enough to back up the input.
      if (p == 1)
        hold_requests++;
    end

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_answers.size() != 0)
      report_mismatch("result beats never delivered", expected_answers.size(), 0);
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
